/* rtl/prq_pkg.sv */
// Package for the priority run queue scheduler.
// Holds action codes, widths and the sequencer state type; no dependencies.
package prq_pkg;

    localparam int NumThreadsDef = 16;
    localparam int NumPrioDef    = 32;
    localparam int TidW          = 4;
    localparam int PrioW         = 5;
    localparam int SliceW        = 8;
    localparam int ActW          = 3;
    localparam logic [SliceW-1:0] QuantumReset = 8'd5;
    localparam logic [PrioW-1:0]  LowestUserPrio = 5'd1;

    localparam logic [ActW-1:0] ACT_MAKE_READY = 3'd0;
    localparam logic [ActW-1:0] ACT_TICK       = 3'd1;
    localparam logic [ActW-1:0] ACT_PREEMPT    = 3'd2;
    localparam logic [ActW-1:0] ACT_YIELD      = 3'd3;
    localparam logic [ActW-1:0] ACT_LEAVE      = 3'd4;
    localparam logic [ActW-1:0] ACT_SET_PRIO   = 3'd5;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ENQ   = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_POP   = 6'b001000,
        ST_SEL   = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

/* rtl/prq_prio_scan.sv */
// Highest-set-bit search over the nonempty bitmap, one bit per cycle.
// Depends on prq_pkg.
module prq_prio_scan
    import prq_pkg::*;
#(
    parameter int NUM_PRIO_LEVELS = NumPrioDef
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [NUM_PRIO_LEVELS-1:0] bitmap,
    output logic                       done,
    output logic                       found,
    output logic [PrioW-1:0]           level
);
    logic [PrioW-1:0] idx_reg, idx_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             found_reg, found_next;

    always_comb begin
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        found_next = found_reg;
        if (start) begin
            idx_next  = PrioW'(NUM_PRIO_LEVELS - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (bitmap[idx_reg]) begin
                busy_next = 1'b0; done_next = 1'b1; found_next = 1'b1;
            end else if (idx_reg == '0) begin
                busy_next = 1'b0; done_next = 1'b1; found_next = 1'b0;
            end else begin
                idx_next = idx_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0; done_reg <= 1'b0; found_reg <= 1'b0; idx_reg <= '0;
        end else begin
            busy_reg <= busy_next; done_reg <= done_next;
            found_reg <= found_next; idx_reg <= idx_next;
        end
    end

    assign done  = done_reg;
    assign found = found_reg;
    assign level = idx_reg;
endmodule

/* rtl/priority_run_queue_scheduler_core.sv */
// Each item passes through ST_ENQ and ST_OUT; one that reschedules also passes through
// ST_SCAN, ST_POP (only when a level is found) and ST_SEL in between, and the bitmap scan
// advances one level per cycle.
// The result waits in an output register; the next item is accepted once it is taken.
// Reset (aresetn low, synchronous) clears the bitmap and slices and makes idle run.
// Top level of the priority run queue scheduler; depends on prq_pkg, prq_prio_scan.
module priority_run_queue_scheduler_core
    import prq_pkg::*;
#(
    parameter int NUM_THREADS     = NumThreadsDef,
    parameter int NUM_PRIO_LEVELS = NumPrioDef
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,  // action[2:0], thread_id[6:3], priority_req[11:7]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata   // running_id[3:0], running_is_idle[4], switched[5],
                                  // resched_request[6], quantum_left[14:7]
);
    localparam int TW = $clog2(NUM_THREADS);
    localparam int QW = $clog2(NUM_PRIO_LEVELS);

    state_t state_reg, state_next;
    logic [SliceW-1:0] quantum_reg;
    logic [NUM_PRIO_LEVELS-1:0] bitmap_reg;
    logic [TW-1:0] head_reg [NUM_PRIO_LEVELS];
    logic [TW-1:0] tail_reg [NUM_PRIO_LEVELS];
    logic [TW-1:0] link_reg [NUM_THREADS];
    logic [PrioW-1:0] tprio_reg [NUM_THREADS];
    logic [SliceW-1:0] slice_reg [NUM_THREADS];
    logic [TW-1:0] cur_reg;
    logic idle_reg;
    logic [SliceW-1:0] idle_slice_reg;
    logic [ActW-1:0] act_reg;
    logic [TW-1:0] ent_reg;
    logic ent_head_reg, sched_reg, sw_reg, req_reg;
    logic [TW-1:0] pick_reg;
    logic [15:0] out_reg;
    logic out_valid_reg;

    logic scan_start, scan_done, scan_found;
    logic [PrioW-1:0] scan_level;
    logic [QW-1:0] lvl, eq;
    logic [PrioW-1:0] p_in, p_set;
    logic [ActW-1:0] a_in;
    logic [TidW-1:0] t_in;

    assign a_in = s_tdata[2:0];
    assign t_in = s_tdata[6:3];
    assign p_in = s_tdata[11:7];
    assign lvl  = scan_level[QW-1:0];
    assign eq   = tprio_reg[ent_reg][QW-1:0];
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_tready  = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_reg;
    assign scan_start = (state_reg == ST_ENQ) && sched_reg;

    always_comb begin
        p_set = (p_in < LowestUserPrio) ? LowestUserPrio : p_in;
        if (32'(p_set) > NUM_PRIO_LEVELS - 1) p_set = PrioW'(NUM_PRIO_LEVELS - 1);
    end

    prq_prio_scan #(.NUM_PRIO_LEVELS(NUM_PRIO_LEVELS)) u_scan (
        .aclk(aclk), .aresetn(aresetn), .start(scan_start), .bitmap(bitmap_reg),
        .done(scan_done), .found(scan_found), .level(scan_level)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_ENQ;
            ST_ENQ:  state_next = sched_reg ? ST_SCAN : ST_OUT;
            ST_SCAN: if (scan_done) state_next = scan_found ? ST_POP : ST_SEL;
            ST_POP:  state_next = ST_SEL;
            ST_SEL:  state_next = ST_OUT;
            ST_OUT:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            quantum_reg <= QuantumReset;
            bitmap_reg <= '0;
            cur_reg <= '0;
            idle_reg <= 1'b1;
            idle_slice_reg <= '0;
            out_valid_reg <= 1'b0;
            sched_reg <= 1'b0;
            for (int i = 0; i < NUM_THREADS; i++) slice_reg[i] <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) quantum_reg <= cfg_data;
            if (m_tvalid && m_tready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE: if (s_tvalid && s_tready) begin
                    act_reg <= a_in;
                    sw_reg <= 1'b0; req_reg <= 1'b0;
                    sched_reg <= 1'b0;
                    ent_head_reg <= 1'b0;
                    ent_reg <= cur_reg;
                    case (a_in)
                        ACT_MAKE_READY: if (32'(t_in) < NUM_THREADS) begin
                            ent_reg <= t_in[TW-1:0];
                            tprio_reg[t_in[TW-1:0]] <=
                                (32'(p_in) > NUM_PRIO_LEVELS - 1) ?
                                PrioW'(NUM_PRIO_LEVELS - 1) : p_in;
                            ent_head_reg <= 1'b1;
                        end
                        ACT_TICK: begin
                            if (idle_reg) begin
                                if (idle_slice_reg != 0) idle_slice_reg <= idle_slice_reg - 1'b1;
                                req_reg <= (idle_slice_reg <= 1);
                            end else begin
                                if (slice_reg[cur_reg] != 0)
                                    slice_reg[cur_reg] <= slice_reg[cur_reg] - 1'b1;
                                req_reg <= (slice_reg[cur_reg] <= 1);
                            end
                        end
                        ACT_PREEMPT: begin
                            sched_reg <= 1'b1;
                            ent_head_reg <= !idle_reg && (slice_reg[cur_reg] != 0);
                        end
                        ACT_YIELD: begin
                            sched_reg <= 1'b1;
                            if (idle_reg) idle_slice_reg <= '0;
                            else slice_reg[cur_reg] <= '0;
                        end
                        ACT_LEAVE: sched_reg <= 1'b1;
                        ACT_SET_PRIO: begin
                            sched_reg <= 1'b1;
                            ent_head_reg <= 1'b1;
                            if (!idle_reg) tprio_reg[cur_reg] <= p_set;
                        end
                        default: ;
                    endcase
                end
                ST_ENQ: begin
                    if ((act_reg == ACT_MAKE_READY && ent_head_reg) ||
                        (!idle_reg && (act_reg == ACT_PREEMPT || act_reg == ACT_YIELD ||
                                       act_reg == ACT_SET_PRIO))) begin
                        if (!bitmap_reg[eq]) begin
                            head_reg[eq] <= ent_reg;
                            tail_reg[eq] <= ent_reg;
                            bitmap_reg[eq] <= 1'b1;
                        end else if (ent_head_reg) begin
                            link_reg[ent_reg] <= head_reg[eq];
                            head_reg[eq] <= ent_reg;
                        end else begin
                            link_reg[tail_reg[eq]] <= ent_reg;
                            tail_reg[eq] <= ent_reg;
                        end
                    end
                end
                ST_SCAN: ;
                ST_POP: begin
                    pick_reg <= head_reg[lvl];
                    if (head_reg[lvl] == tail_reg[lvl]) bitmap_reg[lvl] <= 1'b0;
                    else head_reg[lvl] <= link_reg[head_reg[lvl]];
                end
                ST_SEL: begin
                    if (!scan_found) begin
                        if (!idle_reg) begin
                            sw_reg <= 1'b1;
                            idle_reg <= 1'b1;
                            cur_reg <= '0;
                            if (idle_slice_reg == 0) idle_slice_reg <= quantum_reg;
                        end
                    end else if (idle_reg || pick_reg != cur_reg) begin
                        sw_reg <= 1'b1;
                        idle_reg <= 1'b0;
                        cur_reg <= pick_reg;
                        if (slice_reg[pick_reg] == 0) slice_reg[pick_reg] <= quantum_reg;
                    end
                end
                ST_OUT: begin
                    out_valid_reg <= 1'b1;
                    out_reg <= {1'b0, (idle_reg ? idle_slice_reg : slice_reg[cur_reg]),
                                req_reg, sw_reg, idle_reg,
                                (idle_reg ? 4'd0 : 4'(cur_reg))};
                end
                default: ;
            endcase
        end
    end
endmodule

/* rtl/prq_checker.sv */
// Port-level checker for the scheduler core, bound to the top level.
// Depends on priority_run_queue_scheduler_core.
module prq_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    a_idle_id: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[4] |-> m_tdata[3:0] == 4'd0) else $error("idle id");
    a_no_accept_while_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("accept while result pending");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
    a_req_no_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[6] |-> !m_tdata[5]) else $error("tick switched");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
endmodule

bind priority_run_queue_scheduler_core prq_checker u_prq_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

/* test/testbench.sv */
// Self-checking testbench for priority_run_queue_scheduler_core.
// Predicts each scheduler result in SystemVerilog and compares it field by field;
// depends on prq_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module testbench;
    import prq_pkg::*;

    localparam int NT = 16;
    localparam int NP = 32;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [7:0] quantum_left;
        logic       resched_request;
        logic       switched;
        logic       running_is_idle;
        logic [3:0] running_id;
    } sched_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [7:0]  cfg_data = 8'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    // Predictor state.
    logic [7:0]  pq_reload;
    logic [31:0] pq_bitmap;
    logic [3:0]  pq_head [NP];
    logic [3:0]  pq_tail [NP];
    logic [3:0]  pq_link [NT];
    logic [4:0]  pq_prio [NT];
    logic [7:0]  pq_slice [NT];
    logic [3:0]  pq_cur;
    logic        pq_idle;
    logic [7:0]  pq_idle_slice;

    sched_result_t expected_results[$];
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  sink_stall = 1'b1;
    bit  source_stall = 1'b1;
    int  ready_mask = 0;

    priority_run_queue_scheduler_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    task automatic model_reset();
        pq_reload = QuantumReset;
        pq_bitmap = '0;
        for (int i = 0; i < NP; i++) begin
            pq_head[i] = '0;
            pq_tail[i] = '0;
        end
        for (int i = 0; i < NT; i++) begin
            pq_link[i] = '0;
            pq_prio[i] = '0;
            pq_slice[i] = '0;
        end
        pq_cur = '0;
        pq_idle = 1'b1;
        pq_idle_slice = '0;
    endtask

    task automatic queue_thread(input logic [3:0] t, input bit at_head);
        logic [4:0] q;
        q = pq_prio[t];
        if (!pq_bitmap[q]) begin
            pq_head[q] = t;
            pq_tail[q] = t;
            pq_bitmap[q] = 1'b1;
        end else if (at_head) begin
            pq_link[t] = pq_head[q];
            pq_head[q] = t;
        end else begin
            pq_link[pq_tail[q]] = t;
            pq_tail[q] = t;
        end
    endtask

    function automatic bit pick_next();
        logic [3:0] t;
        bit found;
        found = 1'b0;
        t = '0;
        for (int q = NP - 1; q >= 0; q--) begin
            if (!found && pq_bitmap[q]) begin
                found = 1'b1;
                t = pq_head[q];
                if (pq_head[q] == pq_tail[q]) pq_bitmap[q] = 1'b0;
                else pq_head[q] = pq_link[t];
            end
        end
        if (!found) begin
            if (pq_idle) return 1'b0;
            pq_idle = 1'b1;
            pq_cur = '0;
            if (pq_idle_slice == 0) pq_idle_slice = pq_reload;
            return 1'b1;
        end
        if (!pq_idle && t == pq_cur) return 1'b0;
        pq_idle = 1'b0;
        pq_cur = t;
        if (pq_slice[t] == 0) pq_slice[t] = pq_reload;
        return 1'b1;
    endfunction

    task automatic predict_event(input logic [2:0] act, input logic [3:0] tid,
                                 input logic [4:0] prio);
        sched_result_t r;
        logic [7:0] s;
        logic [4:0] p;
        r = '0;
        p = prio;
        s = pq_idle ? pq_idle_slice : pq_slice[pq_cur];
        case (act)
            ACT_MAKE_READY: begin
                pq_prio[tid] = p;
                queue_thread(tid, 1'b1);
            end
            ACT_TICK: begin
                if (s > 0) s = s - 8'd1;
                if (pq_idle) pq_idle_slice = s;
                else pq_slice[pq_cur] = s;
                r.resched_request = (s == 0);
            end
            ACT_PREEMPT: begin
                if (!pq_idle) queue_thread(pq_cur, pq_slice[pq_cur] > 0);
                r.switched = pick_next();
            end
            ACT_YIELD: begin
                if (pq_idle) pq_idle_slice = '0;
                else begin
                    pq_slice[pq_cur] = '0;
                    queue_thread(pq_cur, 1'b0);
                end
                r.switched = pick_next();
            end
            ACT_LEAVE: r.switched = pick_next();
            ACT_SET_PRIO: begin
                if (!pq_idle) begin
                    if (p < LowestUserPrio) p = LowestUserPrio;
                    pq_prio[pq_cur] = p;
                    queue_thread(pq_cur, 1'b1);
                end
                r.switched = pick_next();
            end
            default: ;
        endcase
        r.running_id = pq_idle ? 4'd0 : pq_cur;
        r.running_is_idle = pq_idle;
        r.quantum_left = pq_idle ? pq_idle_slice : pq_slice[pq_cur];
        expected_results.push_back(r);
    endtask

    task automatic send_event(input logic [2:0] act, input logic [3:0] tid,
                              input logic [4:0] prio);
        @(negedge aclk);
        if (source_stall && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        s_tdata <= {4'd0, prio, tid, act};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_event(act, tid, prio);
        @(negedge aclk);
        s_tvalid <= 1'b0;
    endtask

    task automatic write_reload(input logic [7:0] value);
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (NP + 10) @(negedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        pq_reload = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Once threads have queue entries, every event reads only written table cells.
    task automatic test_directed();
        send_event(ACT_TICK, 4'd0, 5'd0);
        send_event(ACT_LEAVE, 4'd0, 5'd0);
        send_event(ACT_PREEMPT, 4'd0, 5'd0);
        send_event(ACT_YIELD, 4'd0, 5'd31);
        send_event(ACT_SET_PRIO, 4'd0, 5'd31);
        send_event(3'd6, 4'd0, 5'd0);
        send_event(3'd7, 4'd15, 5'd31);
        send_event(ACT_MAKE_READY, 4'd15, 5'd31);
        send_event(ACT_MAKE_READY, 4'd0, 5'd0);
        send_event(ACT_MAKE_READY, 4'd7, 5'd31);
        send_event(ACT_LEAVE, 4'd0, 5'd0);
        send_event(ACT_TICK, 4'd0, 5'd0);
        send_event(ACT_PREEMPT, 4'd0, 5'd0);
        send_event(ACT_SET_PRIO, 4'd0, 5'd0);
        send_event(ACT_SET_PRIO, 4'd0, 5'd31);
        send_event(ACT_YIELD, 4'd0, 5'd0);
        repeat (6) send_event(ACT_TICK, 4'd0, 5'd0);
        send_event(ACT_PREEMPT, 4'd0, 5'd0);
        send_event(ACT_MAKE_READY, 4'd15, 5'd31);
        send_event(ACT_LEAVE, 4'd0, 5'd0);
    endtask

    task automatic test_random(input int count);
        logic [2:0] act;
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 30) act = ACT_MAKE_READY;
            else if (sel < 55) act = ACT_TICK;
            else if (sel < 66) act = ACT_PREEMPT;
            else if (sel < 76) act = ACT_YIELD;
            else if (sel < 86) act = ACT_LEAVE;
            else if (sel < 96) act = ACT_SET_PRIO;
            else act = 3'($urandom_range(6, 7));
            send_event(act, 4'($urandom_range(0, 15)), 5'($urandom_range(0, 31)));
        end
    endtask

    task automatic test_reload_settings();
        write_reload(8'd1);
        test_random(300);
        write_reload(8'd255);
        test_random(300);
        write_reload(8'd0);
        test_random(200);
        write_reload(8'($urandom_range(2, 20)));
        test_random(300);
    endtask

    task automatic test_no_idling();
        source_stall = 1'b0;
        sink_stall = 1'b0;
        test_random(400);
    endtask

    always @(negedge aclk) begin
        if (sink_stall && ready_mask == 0 && $urandom_range(0, 4) == 0)
            ready_mask = $urandom_range(1, 3);
        if (ready_mask > 0) begin
            m_tready <= 1'b0;
            ready_mask = ready_mask - 1;
        end else begin
            m_tready <= aresetn;
        end
    end

    always @(posedge aclk) begin
        sched_result_t got, want;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
            || (expected_results.size() == 0 && !s_tvalid))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("testbench: FAIL");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got = sched_result_t'(m_tdata[14:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.running_id !== want.running_id)
                    $display("%0t: running_id exp %0d got %0d", $time,
                             want.running_id, got.running_id);
                if (got.running_is_idle !== want.running_is_idle)
                    $display("%0t: running_is_idle exp %0d got %0d", $time,
                             want.running_is_idle, got.running_is_idle);
                if (got.switched !== want.switched)
                    $display("%0t: switched exp %0d got %0d", $time,
                             want.switched, got.switched);
                if (got.resched_request !== want.resched_request)
                    $display("%0t: resched_request exp %0d got %0d", $time,
                             want.resched_request, got.resched_request);
                if (got.quantum_left !== want.quantum_left)
                    $display("%0t: quantum_left exp %0d got %0d", $time,
                             want.quantum_left, got.quantum_left);
                if (got !== want) errors++;
            end
        end
    end

    initial begin
        model_reset();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random(200);
        test_reload_settings();
        test_no_idling();
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (NP + 10) @(posedge aclk);
        if (errors == 0 && expected_results.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end
endmodule

/* priority_run_queue_scheduler_core.f */
rtl/prq_pkg.sv
rtl/prq_prio_scan.sv
rtl/priority_run_queue_scheduler_core.sv
rtl/prq_checker.sv
test/testbench.sv
